@@ hw/rtl/lgk3d_pkg.sv @@
package lgk3d_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int ROOT_W = 58;            // significant bits of the normalized root
  localparam int NORM_W = 2 * ROOT_W;    // normalized radicand
  localparam int LEN_W = 6;              // digit count / normalize shift
  localparam int CK_W = 61;
  localparam int CK_LOW = 4;             // dividend bits not already below the divisor
  localparam int QUO_W = CK_LOW + 32;    // quotient bits before the final scale
  localparam logic [CK_W-1:0] INV_FOUR_PI = 61'd1467945251641000613;
  localparam logic [31:0] POT_MAX_FINITE = 32'd341782638;

  typedef struct packed {
    logic             coinc;
    logic [LEN_W-1:0] ndig;
  } lgk_side_t;

endpackage

@@ hw/rtl/laplace_green_kernel_3d_unit.sv @@
// Laplace single-layer kernel 1/(4*pi*r) for one test/trial point pair per beat.
// Coordinates are signed fixed point (Q8.16 at the default width); the result is
// unsigned Q16.16, rounded to nearest. Coincident points give 0xFFFFFFFF with the
// coincident flag (tuser) set. Fully pipelined: one beat in and one beat out per
// cycle unless the output stalls (7 front stages, 58 square-root digit stages, 36
// divide stages, 2 scaling stages, the last being the output register). A stall
// on the output holds the whole pipeline; no beat is lost or repeated.
module laplace_green_kernel_3d_unit #(
  parameter int COORD_WIDTH = lgk3d_pkg::COORD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // test_x, test_y, test_z, trial_x, trial_y, trial_z (lowest first), zero pad
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // potential
  output logic [31:0]             m_axis_tdata,
  // coincident
  output logic [0:0]              m_axis_tuser
);
  localparam int CW = COORD_WIDTH;
  localparam int SW = 2 * CW + 2;          // squared distance
  localparam int ND = SW / 2;              // base-4 digits of it
  localparam int NG = (ND + 3) / 4;        // digit groups for the length search
  localparam int LW = lgk3d_pkg::LEN_W;
  localparam int NW = lgk3d_pkg::NORM_W;
  localparam int QW = lgk3d_pkg::QUO_W;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: absolute differences
  logic          v1;
  logic [CW-1:0] ad1 [0:2];
  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic [CW-1:0] a, b;
    logic [CW:0]   d;
    assign a = s_axis_tdata[i*CW +: CW];
    assign b = s_axis_tdata[(i+3)*CW +: CW];
    assign d = {a[CW-1], a} - {b[CW-1], b};
    always_ff @(posedge clk) begin
      if (en) begin
        ad1[i] <= d[CW] ? CW'(-d) : d[CW-1:0];
      end
    end
  end

  // stage 2: squares
  logic            v2;
  logic [2*CW-1:0] sq2 [0:2];
  // stage 3: sum
  logic          v3;
  logic [SW-1:0] s3;
  // stage 4: per-group digit search
  logic           v4;
  logic [NG*8-1:0] s4;
  logic [NG-1:0]  gany4;
  logic [1:0]     gtop4 [0:NG-1];
  // stage 5: digit count
  logic            v5;
  logic [NG*8-1:0] s5;
  lgk3d_pkg::lgk_side_t side5;
  // stages 6, 7: normalize shift
  logic                 v6, v7;
  logic [NW-1:0]        n6, n7;
  logic [2:0]           ffine6;
  lgk3d_pkg::lgk_side_t side6, side7;

  logic [NG*8-1:0] s3x;
  logic [LW-1:0]   len_c;
  logic [LW-1:0]   f5;
  assign s3x = (NG*8)'(s3);
  assign f5  = LW'(lgk3d_pkg::ROOT_W) - side5.ndig;

  always_comb begin
    len_c = '0;
    for (int g = 0; g < NG; g++) begin
      if (gany4[g]) begin
        len_c = LW'(g * 4) + LW'(gtop4[g]) + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= (2*CW)'(ad1[i]) * (2*CW)'(ad1[i]);
      end
      s3 <= SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]);
      s4 <= s3x;
      for (int g = 0; g < NG; g++) begin
        gany4[g] <= |s3x[g*8 +: 8];
        priority if (|s3x[g*8+6 +: 2]) gtop4[g] <= 2'd3;
        else if (|s3x[g*8+4 +: 2]) gtop4[g] <= 2'd2;
        else if (|s3x[g*8+2 +: 2]) gtop4[g] <= 2'd1;
        else gtop4[g] <= 2'd0;
      end
      s5          <= s4;
      side5.ndig  <= len_c;
      side5.coinc <= ~|gany4;
      // radicand * 4^F, F = 58 - digits: coarse by 8 digits, then fine
      n6     <= NW'(s5) << {f5[5:3], 4'b0000};
      ffine6 <= f5[2:0];
      side6  <= side5;
      n7     <= n6 << {ffine6, 1'b0};
      side7  <= side6;
    end
  end

  logic                           vs;
  logic [lgk3d_pkg::ROOT_W-1:0]   root_s;
  lgk3d_pkg::lgk_side_t           side_s;

  lgk3d_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_rad    (n7),
    .in_side   (side7),
    .out_valid (vs),
    .out_root  (root_s),
    .out_side  (side_s)
  );

  logic                 vd;
  logic [QW-1:0]        quo_d;
  lgk3d_pkg::lgk_side_t side_d;

  lgk3d_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vs),
    .in_root   (root_s),
    .in_side   (side_s),
    .out_valid (vd),
    .out_quo   (quo_d),
    .out_side  (side_d)
  );

  // quotient holds 2^32 scale; drop to 2^(33-digits), then round off 7 bits
  logic          v8;
  logic [QW-1:0] w8;
  logic          c8;
  logic [QW:0]   rnd;
  assign rnd = {1'b0, w8} + (QW+1)'(64);

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      v8 <= vd;
      m_axis_tvalid <= v8;
    end
    if (en) begin
      w8 <= quo_d >> (side_d.ndig - LW'(1));
      c8 <= side_d.coinc;
      m_axis_tuser[0] <= c8;
      m_axis_tdata    <= c8 ? '1 : 32'(rnd[QW:7]);
    end
  end

  a_coinc_sat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '1)
    else $error("coincident beat not saturated");

  a_finite_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata <= lgk3d_pkg::POT_MAX_FINITE)
    else $error("finite potential out of range");

  a_root_norm: assert property (@(posedge clk) disable iff (rst)
    vs && !side_s.coinc |-> root_s[lgk3d_pkg::ROOT_W-1])
    else $error("root not normalized");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    v5 && !side5.coinc |-> side5.ndig != '0 && side5.ndig <= LW'(ND))
    else $error("digit count out of range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
endmodule

@@ hw/rtl/lgk3d_sqrt.sv @@
module lgk3d_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [lgk3d_pkg::NORM_W-1:0]  in_rad,
  input  lgk3d_pkg::lgk_side_t          in_side,
  output logic                          out_valid,
  output logic [lgk3d_pkg::ROOT_W-1:0]  out_root,
  output lgk3d_pkg::lgk_side_t          out_side
);
  localparam int N = lgk3d_pkg::ROOT_W;
  localparam int RW = N + 2;   // remainder never exceeds 2*root

  logic                             v    [0:N];
  logic [lgk3d_pkg::NORM_W-1:0]     rad  [0:N];
  logic [RW-1:0]                    rem  [0:N];
  logic [N-1:0]                     root [0:N];
  lgk3d_pkg::lgk_side_t             side [0:N];

  assign v[0]    = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  // one radicand digit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW+1:0] remt;
    logic [RW+1:0] trial;
    logic          take;
    assign remt  = {rem[k], rad[k][lgk3d_pkg::NORM_W-1-2*k -: 2]};
    assign trial = {2'b00, root[k], 2'b01};
    assign take  = remt >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
      if (en) begin
        rad[k+1]  <= rad[k];
        side[k+1] <= side[k];
        if (take) begin
          rem[k+1]  <= RW'(remt - trial);
          root[k+1] <= {root[k][N-2:0], 1'b1};
        end else begin
          rem[k+1]  <= RW'(remt);
          root[k+1] <= {root[k][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[N];
  assign out_root  = root[N];
  assign out_side  = side[N];
endmodule

@@ hw/rtl/lgk3d_div.sv @@
module lgk3d_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [lgk3d_pkg::ROOT_W-1:0]  in_root,
  input  lgk3d_pkg::lgk_side_t          in_side,
  output logic                          out_valid,
  output logic [lgk3d_pkg::QUO_W-1:0]   out_quo,
  output lgk3d_pkg::lgk_side_t          out_side
);
  localparam int N = lgk3d_pkg::QUO_W;
  localparam int DW = lgk3d_pkg::ROOT_W;
  localparam int LOW = lgk3d_pkg::CK_LOW;
  // upper dividend bits are already below any normalized divisor
  localparam logic [DW-1:0] R_INIT =
    DW'(lgk3d_pkg::INV_FOUR_PI >> LOW);

  logic                   v    [0:N];
  logic [DW-1:0]          dvs  [0:N];
  logic [DW-1:0]          r    [0:N];
  logic [N-1:0]           q    [0:N];
  lgk3d_pkg::lgk_side_t   side [0:N];

  assign v[0]    = in_valid;
  assign dvs[0]  = in_root;
  assign r[0]    = R_INIT;
  assign q[0]    = '0;
  assign side[0] = in_side;

  // restoring division, one quotient bit per stage; dividend continues in zeros
  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam logic DBIT = (j < LOW) ? lgk3d_pkg::INV_FOUR_PI[(j < LOW) ? LOW-1-j : 0]
                                      : 1'b0;
    logic [DW:0] t;
    logic        take;
    assign t    = {r[j], DBIT};
    assign take = t >= {1'b0, dvs[j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else if (en) begin
        v[j+1] <= v[j];
      end
      if (en) begin
        dvs[j+1]  <= dvs[j];
        side[j+1] <= side[j];
        if (take) begin
          r[j+1] <= DW'(t - {1'b0, dvs[j]});
          q[j+1] <= {q[j][N-2:0], 1'b1};
        end else begin
          r[j+1] <= DW'(t);
          q[j+1] <= {q[j][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[N];
  assign out_quo   = q[N];
  assign out_side  = side[N];
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int CW = lgk3d_pkg::COORD_WIDTH_DEF;
  localparam int RANDOM_BEATS = 1150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_LATENCY = 103;
  localparam int HOLD_CYCLES = 400;   // well past the pipeline depth

  typedef logic [5:0][CW-1:0] pair_t;   // [0] test_x ... [5] trial_z

  typedef struct packed {
    logic [31:0] potential;
    logic        coincident;
  } green_t;

  typedef struct {
    pair_t  pair;
    bit     typed;
    green_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // test_x, test_y, test_z, trial_x, trial_y, trial_z (lowest first)
  logic [((6*CW+7)/8)*8-1:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // potential
  logic [31:0] m_axis_tdata;
  // coincident
  logic [0:0]  m_axis_tuser;

  green_t      green_q[$];     // potentials still owed by the pipeline
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  bit          calm = 1'b0;    // no idling on either side while set
  int          hold_req = 0;   // bumped by the sender to ask for a long output stall
  int          hold_seen = 0;
  int          hold_left = 0;

  laplace_green_kernel_3d_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bit-exact 1/(4*pi*r): exact squared distance, 58-digit root of the normalized
  // radicand, long division of the Q64 constant, round half up to Q16.16.
  function automatic green_t green_of_pair(input pair_t p);
    logic [CW:0]   d;
    logic [63:0]   sq_sum;
    logic [127:0]  rem;
    logic [63:0]   root, trial, quo, rmd;
    logic [1:0]    dg;
    int            top, ndig, pos;
    green_t        g;
    sq_sum = '0;
    for (int a = 0; a < 3; a++) begin
      d = {p[a][CW-1], p[a]} - {p[a+3][CW-1], p[a+3]};
      if (d[CW]) d = -d;
      sq_sum += 64'(d) * 64'(d);
    end
    if (sq_sum == 0) begin
      g.potential = 32'hFFFF_FFFF;
      g.coincident = 1'b1;
      return g;
    end
    top = 0;
    for (int i = 0; i < 64; i++)
      if (sq_sum[i]) top = i;
    ndig = top / 2 + 1;
    rem = '0;
    root = '0;
    for (int i = 0; i < lgk3d_pkg::ROOT_W; i++) begin
      pos = ndig - 1 - i;
      dg = (pos >= 0) ? sq_sum[2*pos +: 2] : 2'd0;
      rem = (rem << 2) | 128'(dg);
      trial = (root << 2) | 64'd1;
      if (rem >= 128'(trial)) begin
        rem -= 128'(trial);
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    quo = 64'(lgk3d_pkg::INV_FOUR_PI) / root;
    rmd = 64'(lgk3d_pkg::INV_FOUR_PI) % root;
    for (int i = 0; i < 33 - ndig; i++) begin
      rmd = rmd << 1;
      quo = quo << 1;
      if (rmd >= root) begin
        rmd -= root;
        quo[0] = 1'b1;
      end
    end
    g.potential = 32'((quo + 64'd64) >> 7);
    g.coincident = 1'b0;
    return g;
  endfunction

  function automatic pair_t mk_pair(input int tx, ty, tz, rx, ry, rz);
    pair_t p;
    p[0] = CW'(tx); p[1] = CW'(ty); p[2] = CW'(tz);
    p[3] = CW'(rx); p[4] = CW'(ry); p[5] = CW'(rz);
    return p;
  endfunction

  // Random pair: coincident, near (small per-axis offsets, large potentials)
  // or anywhere in the coordinate range.
  function automatic pair_t rand_pair();
    pair_t p;
    int    mode, k;
    for (int i = 0; i < 6; i++) p[i] = CW'($urandom);
    mode = $urandom_range(99);
    if (mode < 10) begin
      for (int i = 0; i < 3; i++) p[i+3] = p[i];
    end else if (mode < 55) begin
      for (int i = 0; i < 3; i++) begin
        k = $urandom_range(CW - 2);
        p[i+3] = p[i] + CW'($urandom_range((1 << k) - 1)) - CW'(1 << (k - 1 < 0 ? 0 : k - 1));
      end
    end
    return p;
  endfunction

  // One beat into the pipeline; the expectation is queued on acceptance.
  task automatic send_pair(input pair_t p, input bit typed, input green_t want);
    green_t calc;
    calc = green_of_pair(p);
    if (typed && calc !== want) begin
      $error("predictor potential exp %0d got %0d", want.potential, calc.potential);
      err_cnt++;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    do @(posedge clk); while (!s_axis_tready);
    green_q.push_back(typed ? want : calc);
    if (!calm && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Output side: random stalls, plus the long hold when requested.
  always @(posedge clk) begin
    green_t exp_g;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (green_q.size() == 0) begin
        $error("unexpected beat potential=%0d", m_axis_tdata);
        err_cnt++;
      end else begin
        exp_g = green_q.pop_front();
        if (m_axis_tdata !== exp_g.potential) begin
          $error("potential exp %0d got %0d", exp_g.potential, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tuser[0] !== exp_g.coincident) begin
          $error("coincident exp %0d got %0d", exp_g.coincident, m_axis_tuser[0]);
          err_cnt++;
        end
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    green_t    none;
    localparam int CMAX = (1 << (CW - 1)) - 1;
    localparam int CMIN = -(1 << (CW - 1));
    none = '0;

    // Coincident points saturate; one LSB apart gives the largest finite value.
    r.typed = 1; r.want = '{32'hFFFF_FFFF, 1'b1};
    r.pair = mk_pair(0, 0, 0, 0, 0, 0);                         rows.push_back(r);
    r.pair = mk_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);       rows.push_back(r);
    r.pair = mk_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);       rows.push_back(r);
    r.pair = mk_pair(CMIN, 5, CMAX, CMIN, 5, CMAX);             rows.push_back(r);
    r.want = '{lgk3d_pkg::POT_MAX_FINITE, 1'b0};
    r.pair = mk_pair(1, 0, 0, 0, 0, 0);                         rows.push_back(r);
    r.pair = mk_pair(0, 0, 0, 0, 0, -1);                        rows.push_back(r);
    r.pair = mk_pair(0, CMAX, 0, 0, CMAX - 1, 0);               rows.push_back(r);
    r.pair = mk_pair(CMIN, 0, 0, CMIN + 1, 0, 0);               rows.push_back(r);
    // Remaining rows go through the predictor.
    r.typed = 0; r.want = none;
    r.pair = mk_pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);       rows.push_back(r);
    r.pair = mk_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);       rows.push_back(r);
    r.pair = mk_pair(CMAX, 0, 0, CMIN, 0, 0);                   rows.push_back(r);
    r.pair = mk_pair(65536, 0, 0, 0, 0, 0);                     rows.push_back(r);
    r.pair = mk_pair(0, -65536, 0, 0, 65536, 0);                rows.push_back(r);
    r.pair = mk_pair(1, 1, 1, 0, 0, 0);                         rows.push_back(r);
    r.pair = mk_pair(-1, 0, 1, 0, 0, 0);                        rows.push_back(r);
    r.pair = mk_pair(3, 4, 0, 0, 0, 0);                         rows.push_back(r);
    r.pair = mk_pair(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN);       rows.push_back(r);
    r.pair = mk_pair(-1, -1, -1, CMAX, CMAX, CMAX);             rows.push_back(r);
    r.pair = mk_pair(12345, -6789, 1000000, -2000, 777, 3);     rows.push_back(r);
    r.pair = mk_pair(2, 0, 0, 0, 0, 0);                         rows.push_back(r);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_pair(rows[i].pair, rows[i].typed, rows[i].want);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 200) calm = 1'b1;
      if (n == 400) calm = 1'b0;
      if (n == 500) hold_req = hold_req + 1;   // sender keeps pushing into a stalled pipe
      if (n == 800) begin
        // sender goes quiet until the pipeline has drained
        s_axis_tvalid <= 1'b0;
        wait (green_q.size() == 0);
        @(posedge clk);
      end
      send_pair(rand_pair(), 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    wait (green_q.size() == 0);
    repeat (PIPE_LATENCY + 40) @(posedge clk);
    if (err_cnt == 0 && green_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lgk3d_pkg.sv
hw/rtl/lgk3d_sqrt.sv
hw/rtl/lgk3d_div.sv
hw/rtl/laplace_green_kernel_3d_unit.sv
tb/tb.sv
